// ===== rtl/aes_pkg.sv =====
// AES-128 package: S-box functions, GF(2^8) helpers and round transforms.
// Used by the round cell, the key cell and the top level.
package aes_pkg;

   localparam int NumRounds = 10;

   typedef logic [127:0] blk_type;
   typedef logic [7:0] byte_type;

   typedef enum logic {
      OP_ENCRYPT = 1'b0,
      OP_DECRYPT = 1'b1
   } op_type;

   typedef enum logic {
      CSR_KEY_HIGH = 1'b0,
      CSR_KEY_LOW  = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } ctl_type;

   function automatic byte_type xtime(input byte_type x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic byte_type fwd_sbox(input byte_type x);
      byte_type t [256];
      t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[x];
   endfunction

   function automatic byte_type rev_sbox(input byte_type x);
      byte_type t [256];
      t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
      return t[x];
   endfunction

   function automatic byte_type get_byte(input blk_type b, input int i);
      return b[127 - 8*i -: 8];
   endfunction

   function automatic blk_type fwd_round(input blk_type b, input logic last);
      blk_type s;
      blk_type m;
      byte_type a0, a1, a2, a3;
      s = '0;
      m = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            s[127 - 8*(r + 4*c) -: 8] = fwd_sbox(get_byte(b, r + 4*((c + r) % 4)));
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(s, 4*c);
         a1 = get_byte(s, 4*c + 1);
         a2 = get_byte(s, 4*c + 2);
         a3 = get_byte(s, 4*c + 3);
         m[127 - 8*(4*c)     -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         m[127 - 8*(4*c + 1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         m[127 - 8*(4*c + 2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         m[127 - 8*(4*c + 3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
      return last ? s : m;
   endfunction

   function automatic blk_type inv_mix(input blk_type b);
      blk_type m;
      byte_type a [4];
      byte_type x2 [4];
      byte_type x4 [4];
      byte_type x8 [4];
      m = '0;
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) begin
            a[k]  = get_byte(b, 4*c + k);
            x2[k] = xtime(a[k]);
            x4[k] = xtime(x2[k]);
            x8[k] = xtime(x4[k]);
         end
         for (int r = 0; r < 4; r++) begin
            m[127 - 8*(4*c + r) -: 8] =
               (x8[r] ^ x4[r] ^ x2[r]) ^
               (x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4]) ^
               (x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4]) ^
               (x8[(r+3)%4] ^ a[(r+3)%4]);
         end
      end
      return m;
   endfunction

   function automatic blk_type inv_shift_sub(input blk_type b);
      blk_type s;
      s = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            s[127 - 8*(r + 4*c) -: 8] = rev_sbox(get_byte(b, r + 4*((c - r + 4) % 4)));
         end
      end
      return s;
   endfunction

   function automatic byte_type rcon(input logic [3:0] rnd);
      byte_type t [11];
      t = '{8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};
      return (rnd <= 4'd10) ? t[rnd] : 8'h00;
   endfunction

   function automatic blk_type next_rkey(input blk_type k, input logic [3:0] rnd);
      logic [31:0] w [4];
      logic [31:0] t;
      blk_type o;
      for (int i = 0; i < 4; i++) w[i] = k[127 - 32*i -: 32];
      t = {fwd_sbox(w[3][23:16]) ^ rcon(rnd), fwd_sbox(w[3][15:8]),
           fwd_sbox(w[3][7:0]), fwd_sbox(w[3][31:24])};
      w[0] = w[0] ^ t;
      w[1] = w[1] ^ w[0];
      w[2] = w[2] ^ w[1];
      w[3] = w[3] ^ w[2];
      o = {w[0], w[1], w[2], w[3]};
      return o;
   endfunction

endpackage

// ===== rtl/aes128_block_cipher.sv =====
// Top level of the AES-128 cipher: key registers, key schedule row, round cell row.
// Depends on aes_pkg, aes_key_cell and aes_round_cell.
// Accepts one request per cycle and is never busy once the key schedule has settled; each
// result appears on rsp_result_high/low with rsp_valid after passing the input key-add stage
// and then the ten round cells. The receiver cannot stall the pipeline.
// After a key write the key schedule row must refill; busy stays high meanwhile.
module aes128_block_cipher import aes_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_type,
   input  logic [63:0] req_data_high,
   input  logic [63:0] req_data_low,
   output logic        rsp_valid,
   output logic [63:0] rsp_result_high,
   output logic [63:0] rsp_result_low,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [63:0] csr_wdata
);

   blk_type key_ff;
   blk_type key_in;
   blk_type rkey [NumRounds+1];
   logic [3:0] settle_ff;
   logic [3:0] settle_in;
   ctl_type ctl [NumRounds+1];
   blk_type data [NumRounds+1];
   ctl_type ctl0_ff;
   blk_type data0_ff;
   blk_type data0_in;
   logic    accept;

   assign csr_ready = 1'b1;
   assign busy      = (settle_ff != 4'd0);
   assign accept    = start && !busy;

   always_comb begin
      key_in    = key_ff;
      settle_in = (settle_ff != 4'd0) ? settle_ff - 4'd1 : 4'd0;
      if (csr_valid) begin
         settle_in = 4'(NumRounds);
         case (csr_idx_type'(csr_index))
            CSR_KEY_HIGH: key_in[127:64] = csr_wdata;
            CSR_KEY_LOW:  key_in[63:0]   = csr_wdata;
            default:      key_in = key_ff;
         endcase
      end
      data0_in = {req_data_high, req_data_low} ^
                 ((op_type'(req_type) == OP_ENCRYPT) ? rkey[0] : rkey[NumRounds]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff    <= '0;
         settle_ff <= 4'(NumRounds);
         ctl0_ff   <= '{valid: 1'b0, op: OP_ENCRYPT};
      end else begin
         key_ff    <= key_in;
         settle_ff <= settle_in;
         ctl0_ff   <= '{valid: accept, op: op_type'(req_type)};
      end
      data0_ff <= data0_in;
   end

   assign rkey[0] = key_ff;
   assign ctl[0]  = ctl0_ff;
   assign data[0] = data0_ff;

   for (genvar i = 1; i <= NumRounds; i++) begin : g_cell
      aes_key_cell #(.RoundIdx(4'(i))) u_key (
         .clock   (clock),
         .key_prev(rkey[i-1]),
         .key_out (rkey[i])
      );
      aes_round_cell u_round (
         .clock    (clock),
         .reset    (reset),
         .ctl_prev (ctl[i-1]),
         .data_prev(data[i-1]),
         .enc_key  (rkey[i]),
         .dec_key  (rkey[NumRounds-i]),
         .last     (i == NumRounds),
         .ctl_out  (ctl[i]),
         .data_out (data[i])
      );
   end

   assign rsp_valid       = ctl[NumRounds].valid;
   assign rsp_result_high = data[NumRounds][127:64];
   assign rsp_result_low  = data[NumRounds][63:0];

   a_busy_after_csr: assert property (@(posedge clock) disable iff (reset)
      csr_valid |=> busy) else $error("busy not raised after key write");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |=> !ctl0_ff.valid) else $error("request entered while busy");
   a_latency: assert property (@(posedge clock) disable iff (reset)
      ctl0_ff.valid |-> ##10 rsp_valid) else $error("result lost in pipeline");

endmodule

// ===== rtl/aes_key_cell.sv =====
// Key cell: derives one round key from the previous round key and holds it in a register.
// Depends on aes_pkg.
module aes_key_cell import aes_pkg::*; #(
   parameter logic [3:0] RoundIdx = 4'd1
) (
   input  logic    clock,
   input  blk_type key_prev,
   output blk_type key_out
);

   blk_type key_ff;
   blk_type key_in;

   assign key_in  = next_rkey(key_prev, RoundIdx);
   assign key_out = key_ff;

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

// ===== rtl/aes_round_cell.sv =====
// Round cell: one registered AES round, encrypt or decrypt selected per request.
// Depends on aes_pkg.
module aes_round_cell import aes_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  ctl_type ctl_prev,
   input  blk_type data_prev,
   input  blk_type enc_key,
   input  blk_type dec_key,
   input  logic    last,
   output ctl_type ctl_out,
   output blk_type data_out
);

   ctl_type ctl_ff;
   blk_type data_ff;
   blk_type data_in;
   blk_type dec_s;

   always_comb begin
      dec_s = inv_shift_sub(data_prev) ^ dec_key;
      if (ctl_prev.op == OP_ENCRYPT) begin
         data_in = fwd_round(data_prev, last) ^ enc_key;
      end else begin
         data_in = last ? dec_s : inv_mix(dec_s);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '{valid: 1'b0, op: OP_ENCRYPT};
      end else begin
         ctl_ff <= ctl_prev;
      end
      data_ff <= data_in;
   end

   assign ctl_out  = ctl_ff;
   assign data_out = data_ff;

endmodule
